>>> sv/bom_pkg.sv
package bom_pkg;

	localparam int MAX_BOXES_DEF  = 64;
	localparam int COORD_BITS_DEF = 12;
	localparam int KIND_W         = 2;
	localparam int RATIO_W        = 4;
	localparam int CFG_IDX_W      = 2;
	localparam int CNT_OUT_W      = 7;

	localparam logic [RATIO_W-1:0] FP_RATIO_RESET = RATIO_W'(3);
	localparam logic [RATIO_W-1:0] TP_RATIO_RESET = RATIO_W'(2);

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR = 2'd0,
		KIND_ADD   = 2'd1,
		KIND_TEST  = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FP_RATIO = 2'd0,
		CFG_TP_RATIO = 2'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic clear;
		logic add;
		logic test;
		logic other;
		logic scan_en;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic pipe_busy;
	} status_t;

endpackage

>>> sv/bom_if.sv
interface bom_in_if import bom_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [KIND_W-1:0]     kind;
	logic [COORD_BITS-1:0] x_min;
	logic [COORD_BITS-1:0] y_min;
	logic [COORD_BITS-1:0] x_max;
	logic [COORD_BITS-1:0] y_max;

	modport source (output valid, kind, x_min, y_min, x_max, y_max, input ready);
	modport sink (input valid, kind, x_min, y_min, x_max, y_max, output ready);
endinterface

interface bom_out_if import bom_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic                 false_positive;
	logic [CNT_OUT_W-1:0] matched_count;
	logic [CNT_OUT_W-1:0] box_count;
	logic                 table_full;

	modport source (output valid, false_positive, matched_count, box_count, table_full,
		input ready);
	modport sink (input valid, false_positive, matched_count, box_count, table_full,
		output ready);
endinterface

interface bom_cfg_if import bom_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [RATIO_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> sv/box_overlap_match_scorer_top.sv
// Ground-truth boxes are added to a table of MAX_BOXES entries and detection boxes are tested
// against every stored entry; each transaction on the item channel returns exactly one result
// transaction with the false-positive flag, the matched and stored counts and the table-full
// flag. Clear, add and the unused kind go from acceptance to the response state, which waits
// for a free output register before the next item is accepted. For a test, the box table
// memory is read one entry per cycle through a four-stage compare pipeline, and the result is
// issued after that pipeline drains. A new item is accepted while the previous result still
// waits in the output register. Configuration writes are always accepted and should only be
// issued while idle.
module box_overlap_match_scorer_top import bom_pkg::*; #(
	parameter int MAX_BOXES  = MAX_BOXES_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	bom_in_if.sink   item,
	bom_out_if.source result,
	bom_cfg_if.sink  cfg
);

	cmd_t    cmd;
	status_t status;
	logic    cfg_we;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;

	bom_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.in_kind   (item.kind),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	bom_datapath #(
		.MAX_BOXES  (MAX_BOXES),
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.x_min              (item.x_min),
		.y_min              (item.y_min),
		.x_max              (item.x_max),
		.y_max              (item.y_max),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg.index),
		.cfg_data           (cfg.data),
		.res_false_positive (result.false_positive),
		.res_matched_count  (result.matched_count),
		.res_box_count      (result.box_count),
		.res_table_full     (result.table_full)
	);

endmodule

>>> sv/bom_ram.sv
module bom_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/bom_ctrl.sv
module bom_ctrl import bom_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [KIND_W-1:0] in_kind,
	output logic              out_valid,
	input  logic              out_ready,
	input  status_t           status,
	output cmd_t              cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (kind_t'(in_kind) == KIND_TEST) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_SCAN: begin
				if (status.scan_done && !status.pipe_busy) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (kind_t'(in_kind))
						KIND_CLEAR: cmd.clear = 1'b1;
						KIND_ADD:   cmd.add   = 1'b1;
						KIND_TEST:  cmd.test  = 1'b1;
						default:    cmd.other = 1'b1;
					endcase
				end
			end
			ST_SCAN: begin
				cmd.scan_en = 1'b1;
			end
			ST_RESP: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/bom_datapath.sv
module bom_datapath import bom_pkg::*; #(
	parameter int MAX_BOXES  = MAX_BOXES_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               status,
	input  logic [COORD_BITS-1:0] x_min,
	input  logic [COORD_BITS-1:0] y_min,
	input  logic [COORD_BITS-1:0] x_max,
	input  logic [COORD_BITS-1:0] y_max,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [RATIO_W-1:0]    cfg_data,
	output logic                  res_false_positive,
	output logic [CNT_OUT_W-1:0]  res_matched_count,
	output logic [CNT_OUT_W-1:0]  res_box_count,
	output logic                  res_table_full
);

	localparam int C      = COORD_BITS;
	localparam int CW1    = C + 1;
	localparam int AREA_W = 2 * CW1;
	localparam int INT_W  = 2 * C;
	localparam int SC_W   = INT_W + RATIO_W + 1;
	localparam int CNT_W  = $clog2(MAX_BOXES + 1);
	localparam int ADDR_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int BOX_W  = 4 * C;
	localparam int WORD_W = BOX_W + 1;

	logic [RATIO_W-1:0] fp_ratio_q;
	logic [RATIO_W-1:0] tp_ratio_q;

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   matched_q;
	logic [CNT_W-1:0]   idx_q;
	logic               fp_q;
	logic               full_q;
	logic               room;

	logic [C-1:0]              det_x0_q, det_y0_q, det_x1_q, det_y1_q;
	logic signed [CW1-1:0]     det_w, det_h;
	logic signed [AREA_W-1:0]  darea_q;

	logic                rd_en;
	logic [WORD_W-1:0]   rd_data;
	logic                we;
	logic [ADDR_W-1:0]   waddr;
	logic [WORD_W-1:0]   wdata;

	logic [C-1:0]          bx0, by0, bx1, by1;
	logic [C-1:0]          ix0, iy0, ix1, iy1;
	logic                  ov;

	logic                     v_s1, v_s2, v_s3, v_s4;
	logic [ADDR_W-1:0]        idx_s1, idx_s2, idx_s3, idx_s4;
	logic                     ov_s2, ov_s3, ov_s4;
	logic                     mark_s2, mark_s3, mark_s4;
	logic [BOX_W-1:0]         box_s2, box_s3, box_s4;
	logic [C-1:0]             spx_s2, spy_s2;
	logic signed [CW1-1:0]    bw_s2, bh_s2;
	logic [INT_W-1:0]         inter_s3;
	logic signed [AREA_W-1:0] barea_s3;
	logic [SC_W-1:0]          fpi_s4, tpi_s4;
	logic signed [AREA_W-1:0] smaller_s4;
	logic signed [SC_W-1:0]   smaller_ext;
	logic                     fp_hit, tp_hit, new_mark;

	assign room             = count_q < CNT_W'(MAX_BOXES);
	assign rd_en            = cmd.scan_en && (idx_q < count_q);
	assign status.scan_done = !(idx_q < count_q);
	assign status.pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_ratio_q <= FP_RATIO_RESET;
			tp_ratio_q <= TP_RATIO_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FP_RATIO: fp_ratio_q <= cfg_data;
				CFG_TP_RATIO: tp_ratio_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			matched_q <= '0;
			idx_q     <= '0;
			fp_q      <= 1'b0;
			full_q    <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q   <= '0;
				matched_q <= '0;
			end else if (cmd.add && room) begin
				count_q <= count_q + CNT_W'(1);
			end else if (new_mark) begin
				matched_q <= matched_q + CNT_W'(1);
			end
			if (cmd.test) begin
				idx_q <= '0;
			end else if (rd_en) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.test) begin
				fp_q <= 1'b1;
			end else if (cmd.clear || cmd.add || cmd.other || fp_hit) begin
				fp_q <= 1'b0;
			end
			if (cmd.add) begin
				full_q <= !room;
			end else if (cmd.clear || cmd.test || cmd.other) begin
				full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.test) begin
			det_x0_q <= x_min;
			det_y0_q <= y_min;
			det_x1_q <= x_max;
			det_y1_q <= y_max;
		end
		darea_q <= AREA_W'(det_w) * AREA_W'(det_h);
	end

	assign det_w = $signed({1'b0, det_x1_q}) - $signed({1'b0, det_x0_q});
	assign det_h = $signed({1'b0, det_y1_q}) - $signed({1'b0, det_y0_q});

	assign we    = (cmd.add && room) || new_mark;
	assign waddr = cmd.add ? count_q[ADDR_W-1:0] : idx_s4;
	assign wdata = cmd.add ? {1'b0, y_max, x_max, y_min, x_min} : {1'b1, box_s4};

	bom_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_BOXES)
	) u_box_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	assign bx0 = rd_data[C-1:0];
	assign by0 = rd_data[2*C-1:C];
	assign bx1 = rd_data[3*C-1:2*C];
	assign by1 = rd_data[4*C-1:3*C];
	assign ix0 = (bx0 > det_x0_q) ? bx0 : det_x0_q;
	assign iy0 = (by0 > det_y0_q) ? by0 : det_y0_q;
	assign ix1 = (bx1 < det_x1_q) ? bx1 : det_x1_q;
	assign iy1 = (by1 < det_y1_q) ? by1 : det_y1_q;
	assign ov  = (ix0 < ix1) && (iy0 < iy1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[ADDR_W-1:0];

		idx_s2  <= idx_s1;
		ov_s2   <= ov;
		mark_s2 <= rd_data[BOX_W];
		box_s2  <= rd_data[BOX_W-1:0];
		spx_s2  <= ix1 - ix0;
		spy_s2  <= iy1 - iy0;
		bw_s2   <= $signed({1'b0, bx1}) - $signed({1'b0, bx0});
		bh_s2   <= $signed({1'b0, by1}) - $signed({1'b0, by0});

		idx_s3   <= idx_s2;
		ov_s3    <= ov_s2;
		mark_s3  <= mark_s2;
		box_s3   <= box_s2;
		inter_s3 <= INT_W'(spx_s2) * INT_W'(spy_s2);
		barea_s3 <= AREA_W'(bw_s2) * AREA_W'(bh_s2);

		idx_s4     <= idx_s3;
		ov_s4      <= ov_s3;
		mark_s4    <= mark_s3;
		box_s4     <= box_s3;
		fpi_s4     <= SC_W'(fp_ratio_q) * SC_W'(inter_s3);
		tpi_s4     <= SC_W'(tp_ratio_q) * SC_W'(inter_s3);
		smaller_s4 <= (barea_s3 > darea_q) ? darea_q : barea_s3;
	end

	assign smaller_ext = SC_W'(smaller_s4);
	assign fp_hit      = v_s4 && ov_s4 && ($signed(fpi_s4) >= smaller_ext);
	assign tp_hit      = v_s4 && ov_s4 && ($signed(tpi_s4) >= smaller_ext);
	assign new_mark    = tp_hit && !mark_s4;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_false_positive <= fp_q;
			res_matched_count  <= CNT_OUT_W'(matched_q);
			res_box_count      <= CNT_OUT_W'(count_q);
			res_table_full     <= full_q;
		end
	end

endmodule
